// ===== rtl/ddpi_pkg.sv =====
// shared constants, tables and helpers for the differential drive pose integrator
package ddpi_pkg;

  localparam int unsigned CORDIC_STEPS_DEF  = 24;
  localparam int unsigned POS_FRAC_BITS_DEF = 16;

  localparam int unsigned VEL_W  = 24;
  localparam int unsigned DT_W   = 24;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned ANG_W  = 32;
  localparam int unsigned QUAT_W = 18;
  localparam int unsigned THR_W  = 8;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic        [31:0] RAD_TO_BAM  = 32'd683565276;
  localparam int unsigned        ANG_SHIFT   = 36;

  // atan(2^-i) as binary angle, 2^31 = pi
  localparam logic [31:0] ATAN_BAM [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // add a sign-magnitude step to a coordinate, saturating at 32 bits
  function automatic logic [31:0] sat_add(input logic [31:0] pos, input logic [63:0] mag,
                                          input logic neg);
    logic signed [65:0] step;
    logic signed [65:0] sum;
    step = $signed({2'b00, mag});
    if (neg) begin
      step = -step;
    end
    sum = $signed({{34{pos[31]}}, pos}) + step;
    if (sum > 66'sh0_7FFF_FFFF) begin
      sat_add = 32'h7FFF_FFFF;
    end else if (sum < -66'sh0_8000_0000) begin
      sat_add = 32'h8000_0000;
    end else begin
      sat_add = sum[31:0];
    end
  endfunction

endpackage

// ===== rtl/diff_drive_pose_integrator.sv =====
// top level: exact-arc differential drive odometry with shared cordic, multiplier and divider
// a straight tick runs the old-heading cordic, the x and y products and the half-heading cordic;
//   an arc tick runs the old-heading cordic, the heading step product, the new-heading cordic, a
//   product and a division each for x and y, and the half-heading cordic, all on the bit-serial
//   multiplier, the restoring divider and the shared cordic, before the hand-over to the result word
// a new tick is taken only once the last one is handed over; the hand-over waits while the output is stalled
// reset: rst_ni clears pose, heading, threshold and all handshake state; no clearing pass
module diff_drive_pose_integrator #(
  parameter int unsigned CORDIC_STEPS  = ddpi_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned POS_FRAC_BITS = ddpi_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ddpi_pkg::THR_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [ddpi_pkg::VEL_W-1:0] linear_velocity_i,
  input  logic signed [ddpi_pkg::VEL_W-1:0] angular_velocity_i,
  input  logic [ddpi_pkg::DT_W-1:0]         elapsed_time_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ddpi_pkg::POS_W-1:0] pos_x_o,
  output logic signed [ddpi_pkg::POS_W-1:0] pos_y_o,
  output logic signed [ddpi_pkg::ANG_W-1:0] heading_o,
  output logic signed [ddpi_pkg::QUAT_W-1:0] quat_z_o,
  output logic signed [ddpi_pkg::QUAT_W-1:0] quat_w_o
);
  import ddpi_pkg::*;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CS0  = 4'd1;   // sin/cos of old heading
  localparam logic [3:0] S_MX   = 4'd2;   // straight x product
  localparam logic [3:0] S_MY   = 4'd3;   // straight y product
  localparam logic [3:0] S_MD   = 4'd4;   // heading step product
  localparam logic [3:0] S_CS1  = 4'd5;   // sin/cos of new heading
  localparam logic [3:0] S_AMX  = 4'd6;   // arc x numerator
  localparam logic [3:0] S_ADX  = 4'd7;   // arc x division
  localparam logic [3:0] S_AMY  = 4'd8;   // arc y numerator
  localparam logic [3:0] S_ADY  = 4'd9;   // arc y division
  localparam logic [3:0] S_CSQ  = 4'd10;  // sin/cos of half heading
  localparam logic [3:0] S_OUT  = 4'd11;  // hand result to output register

  localparam int unsigned STRAIGHT_SHIFT = 66 - POS_FRAC_BITS;
  localparam int unsigned DEN_SHIFT      = 30 - POS_FRAC_BITS;
  localparam logic [6:0]  CORD_LAST      = 7'(CORDIC_STEPS);
  localparam logic [6:0]  MUL_LAST       = 7'd32;
  localparam logic [6:0]  DIV_LAST       = 7'd64;
  localparam logic signed [31:0] QUARTER = 32'sh4000_0000;
  localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;

  logic [3:0]  state_q, state_d;
  logic [6:0]  ucnt_q, ucnt_d;
  logic [THR_W-1:0] thr_q;

  // tick operands
  logic        vneg_q, vneg_d, wneg_q, wneg_d;
  logic [23:0] vmag_q, vmag_d, wmag_q, wmag_d;
  logic [47:0] dist_q, dist_d, wdt_q, wdt_d;

  // pose state
  logic [31:0] pose_x_q, pose_x_d, pose_y_q, pose_y_d, head_q, head_d;

  // cordic unit
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic               flip_q, flip_d;
  logic signed [31:0] s0_q, s0_d, c0_q, c0_d;
  logic signed [32:0] dy_q, dy_d;
  logic               sgn_q, sgn_d;

  // serial multiplier
  logic [79:0] ma_q, ma_d, acc_q, acc_d;
  logic [31:0] mb_q, mb_d;

  // restoring divider
  logic [63:0] dq_q, dq_d, rem_q, rem_d, den_q, den_d;

  // output register
  logic        oval_q, oval_d;
  logic [31:0] ox_q, ox_d, oy_q, oy_d, oh_q, oh_d;
  logic [17:0] oqz_q, oqz_d, oqw_q, oqw_d;

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    logic               cord_load;
    logic [31:0]        cord_ang;
    logic signed [33:0] xs, ys, at, xc, yc;
    logic signed [31:0] csin, ccos;
    logic [79:0]        rnd_pos, rnd_ang;
    logic [63:0]        rem_sh, den_new;
    logic [31:0]        dmag, hnew;
    logic signed [32:0] dx, dyn, qsr, qcr;
    logic [23:0]        vm, wm;

    state_d  = state_q;
    ucnt_d   = ucnt_q;
    vneg_d   = vneg_q;   wneg_d = wneg_q;
    vmag_d   = vmag_q;   wmag_d = wmag_q;
    dist_d   = dist_q;   wdt_d  = wdt_q;
    pose_x_d = pose_x_q; pose_y_d = pose_y_q; head_d = head_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; flip_d = flip_q;
    s0_d = s0_q; c0_d = c0_q; dy_d = dy_q; sgn_d = sgn_q;
    ma_d = ma_q; mb_d = mb_q; acc_d = acc_q;
    dq_d = dq_q; rem_d = rem_q; den_d = den_q;
    oval_d = oval_q; ox_d = ox_q; oy_d = oy_q; oh_d = oh_q; oqz_d = oqz_q; oqw_d = oqw_q;
    cord_load = 1'b0;
    cord_ang  = head_q;

    // cordic step and finished values
    xs = cx_q >>> ucnt_q[4:0];
    ys = cy_q >>> ucnt_q[4:0];
    at = $signed({2'b00, ATAN_BAM[ucnt_q[4:0]]});
    xc = cx_q;
    if (cx_q > ONE_Q30) xc = ONE_Q30;
    if (cx_q < -ONE_Q30) xc = -ONE_Q30;
    yc = cy_q;
    if (cy_q > ONE_Q30) yc = ONE_Q30;
    if (cy_q < -ONE_Q30) yc = -ONE_Q30;
    if (flip_q) begin
      xc = -xc;
      yc = -yc;
    end
    ccos = xc[31:0];
    csin = yc[31:0];

    // rounded multiplier results
    rnd_pos = (acc_q + (80'd1 << (STRAIGHT_SHIFT - 1))) >> STRAIGHT_SHIFT;
    rnd_ang = (acc_q + (80'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;

    rem_sh  = {rem_q[62:0], dq_q[63]};
    den_new = 64'(wmag_q) << DEN_SHIFT;
    dmag    = rnd_ang[31:0];
    hnew    = head_q + (wneg_q ? (32'd0 - dmag) : dmag);
    dx      = 33'(csin) - 33'(s0_q);
    dyn     = 33'(c0_q) - 33'(ccos);
    qsr     = (33'(csin) + 33'sd8192) >>> 14;
    qcr     = (33'(ccos) + 33'sd8192) >>> 14;
    vm      = linear_velocity_i[23] ? 24'(-linear_velocity_i) : 24'(linear_velocity_i);
    wm      = angular_velocity_i[23] ? 24'(-angular_velocity_i) : 24'(angular_velocity_i);

    // output register drains independently
    if (oval_q && !out_stall_i) begin
      oval_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          vneg_d    = linear_velocity_i[23];
          wneg_d    = angular_velocity_i[23];
          vmag_d    = vm;
          wmag_d    = wm;
          dist_d    = vm * elapsed_time_i;
          wdt_d     = wm * elapsed_time_i;
          cord_load = 1'b1;
          cord_ang  = head_q;
          state_d   = S_CS0;
        end
      end
      S_CS0, S_CS1, S_CSQ: begin
        if (ucnt_q != CORD_LAST) begin
          if (!cz_q[33]) begin
            cx_d = cx_q - ys; cy_d = cy_q + xs; cz_d = cz_q - at;
          end else begin
            cx_d = cx_q + ys; cy_d = cy_q - xs; cz_d = cz_q + at;
          end
          ucnt_d = ucnt_q + 7'd1;
        end else begin
          ucnt_d = '0;
          acc_d  = '0;
          if (state_q == S_CS0) begin
            s0_d = csin;
            c0_d = ccos;
            if (wmag_q <= 24'(thr_q)) begin
              // straight line along current heading
              ma_d    = 80'(dist_q);
              mb_d    = ccos[31] ? 32'(-ccos) : 32'(ccos);
              state_d = S_MX;
            end else begin
              ma_d    = 80'(wdt_q);
              mb_d    = RAD_TO_BAM;
              state_d = S_MD;
            end
          end else if (state_q == S_CS1) begin
            dy_d    = dyn;
            sgn_d   = vneg_q ^ wneg_q ^ dx[32];
            ma_d    = 80'(vmag_q);
            mb_d    = dx[32] ? 32'(-dx) : dx[31:0];
            state_d = S_AMX;
          end else begin
            // cordic registers hold the half-angle result until the hand-over
            state_d = S_OUT;
          end
        end
      end
      S_MX, S_MY, S_MD, S_AMX, S_AMY: begin
        if (ucnt_q != MUL_LAST) begin
          if (mb_q[0]) begin
            acc_d = acc_q + ma_q;
          end
          ma_d   = {ma_q[78:0], 1'b0};
          mb_d   = {1'b0, mb_q[31:1]};
          ucnt_d = ucnt_q + 7'd1;
        end else begin
          ucnt_d = '0;
          if (state_q == S_MX) begin
            pose_x_d = sat_add(pose_x_q, rnd_pos[63:0], vneg_q ^ c0_q[31]);
            acc_d    = '0;
            ma_d     = 80'(dist_q);
            mb_d     = s0_q[31] ? 32'(-s0_q) : 32'(s0_q);
            state_d  = S_MY;
          end else if (state_q == S_MY) begin
            pose_y_d  = sat_add(pose_y_q, rnd_pos[63:0], vneg_q ^ s0_q[31]);
            cord_load = 1'b1;
            cord_ang  = {head_q[31], head_q[31:1]};
            state_d   = S_CSQ;
          end else if (state_q == S_MD) begin
            head_d    = hnew;
            cord_load = 1'b1;
            cord_ang  = hnew;
            state_d   = S_CS1;
          end else begin
            // numerator ready, round by adding half the divisor
            den_d   = den_new;
            dq_d    = acc_q[63:0] + (den_new >> 1);
            rem_d   = '0;
            state_d = (state_q == S_AMX) ? S_ADX : S_ADY;
          end
        end
      end
      S_ADX, S_ADY: begin
        if (ucnt_q != DIV_LAST) begin
          if (rem_sh >= den_q) begin
            rem_d = rem_sh - den_q;
            dq_d  = {dq_q[62:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            dq_d  = {dq_q[62:0], 1'b0};
          end
          ucnt_d = ucnt_q + 7'd1;
        end else begin
          ucnt_d = '0;
          if (state_q == S_ADX) begin
            pose_x_d = sat_add(pose_x_q, dq_q, sgn_q);
            sgn_d    = vneg_q ^ wneg_q ^ dy_q[32];
            acc_d    = '0;
            ma_d     = 80'(vmag_q);
            mb_d     = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
            state_d  = S_AMY;
          end else begin
            pose_y_d  = sat_add(pose_y_q, dq_q, sgn_q);
            cord_load = 1'b1;
            cord_ang  = {head_q[31], head_q[31:1]};
            state_d   = S_CSQ;
          end
        end
      end
      S_OUT: begin
        if (!oval_q || !out_stall_i) begin
          oval_d  = 1'b1;
          ox_d    = pose_x_q;
          oy_d    = pose_y_q;
          oh_d    = head_q;
          oqz_d   = qsr[17:0];
          oqw_d   = qcr[17:0];
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // cordic start: fold into [-pi/2, pi/2] by a half turn
    if (cord_load) begin
      ucnt_d = '0;
      cx_d   = CORDIC_GAIN;
      cy_d   = '0;
      flip_d = ($signed(cord_ang) > QUARTER) || ($signed(cord_ang) < -QUARTER);
      if (flip_d) begin
        cord_ang = cord_ang ^ 32'h8000_0000;
      end
      cz_d = 34'($signed(cord_ang));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ucnt_q   <= '0;
      thr_q    <= '0;
      pose_x_q <= '0;
      pose_y_q <= '0;
      head_q   <= '0;
      oval_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ucnt_q   <= ucnt_d;
      pose_x_q <= pose_x_d;
      pose_y_q <= pose_y_d;
      head_q   <= head_d;
      oval_q   <= oval_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    vneg_q <= vneg_d; wneg_q <= wneg_d;
    vmag_q <= vmag_d; wmag_q <= wmag_d;
    dist_q <= dist_d; wdt_q  <= wdt_d;
    cx_q   <= cx_d;   cy_q   <= cy_d;   cz_q <= cz_d; flip_q <= flip_d;
    s0_q   <= s0_d;   c0_q   <= c0_d;   dy_q <= dy_d; sgn_q  <= sgn_d;
    ma_q   <= ma_d;   mb_q   <= mb_d;   acc_q <= acc_d;
    dq_q   <= dq_d;   rem_q  <= rem_d;  den_q <= den_d;
    ox_q   <= ox_d;   oy_q   <= oy_d;   oh_q <= oh_d;
    oqz_q  <= oqz_d;  oqw_q  <= oqw_d;
  end

  assign out_valid_o = oval_q;
  assign pos_x_o     = ox_q;
  assign pos_y_o     = oy_q;
  assign heading_o   = oh_q;
  assign quat_z_o    = oqz_q;
  assign quat_w_o    = oqw_q;

  // a tick always starts with the old-heading cordic pass
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> state_q == S_CS0)
    else $error("tick did not start cordic");
  // a new result only appears when the sequencer hands one over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(oval_q) |-> $past(state_q) == S_OUT)
    else $error("result word without finished tick");
  // the shared step counter never runs past the longest pass
  assert property (@(posedge clk_i) disable iff (!rst_ni) ucnt_q <= DIV_LAST)
    else $error("step counter overrun");
  // a pending result blocks the hand-over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && oval_q && out_stall_i) |=> state_q == S_OUT)
    else $error("result overwritten while stalled");

endmodule
